// ----- hdl/serial_frame_receiver_assert.svh -----
// Assertion macros for the serial frame receiver.
// Each macro samples on clk and is switched off while rst is high.
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define SFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sfr_pkg.sv -----
`default_nettype none

package sfr_pkg;

  // Default frame size in bytes, delimiter included.
  localparam int MAX_FRAME_DEF = 64;

  // Delimiter value after reset.
  localparam logic [7:0] DELIM_RESET = 8'd186;

  // Frame status codes carried on the last beat of a frame.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_FORMAT = 2'd1;
  localparam logic [1:0] ST_BAD_SUM    = 2'd2;
  localparam logic [1:0] ST_TOO_LONG   = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/sfr_store.sv -----
`default_nettype none

module sfr_store #(
  parameter int Depth = sfr_pkg::MAX_FRAME_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [7:0]               wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [7:0]               rdata
);

  logic [7:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/sfr_ctrl.sv -----
`default_nettype none

module sfr_ctrl #(
  parameter int MaxFrame = sfr_pkg::MAX_FRAME_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [7:0]                  delim,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [7:0]                  msg_byte,
  output logic                             has_byte,
  output logic      [1:0]                  frame_status,
  output logic                             last_of_run,
  output logic                             busy,
  output logic                             mem_we,
  output logic      [$clog2(MaxFrame)-1:0] mem_waddr,
  output logic      [7:0]                  mem_wdata,
  output logic      [$clog2(MaxFrame)-1:0] mem_raddr,
  input  wire logic [7:0]                  mem_rdata
);

  localparam int AW = $clog2(MaxFrame);
  localparam int PW = $clog2(MaxFrame + 1);

  localparam logic S_PARSE = 1'b0;
  localparam logic S_EMIT  = 1'b1;

  logic          state, state_next;
  logic [PW-1:0] pos, pos_next;
  logic          half, half_next;
  logic [7:0]    idx, idx_next;
  logic [7:0]    sum, sum_next;
  logic [AW-1:0] ptr;
  logic [AW-1:0] last_ptr;
  logic [PW-1:0] pos_m1;

  logic          slot_free;
  logic          acc;
  logic          is_delim;
  logic          emit_adv;
  logic          ptr_last;
  logic          emit_start;
  logic          item_load;
  logic [1:0]    item_status;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_PARSE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign is_delim  = (rx_byte == delim);
  assign emit_adv  = (state == S_EMIT) && slot_free;
  assign ptr_last  = (ptr == last_ptr);
  assign busy      = (state == S_EMIT);
  assign pos_m1    = pos - PW'(1);

  // Message bytes go to the store at the current frame position.
  assign mem_waddr = pos[AW-1:0];
  assign mem_wdata = rx_byte;

  // Read address runs one ahead of the pointer while the message is played
  // out, and sits on the first message byte while parsing.
  always_comb begin
    if (emit_adv && !ptr_last) begin
      mem_raddr = AW'(ptr + AW'(1));
    end else if (state == S_EMIT) begin
      mem_raddr = ptr;
    end else begin
      mem_raddr = AW'(2);
    end
  end

  // Frame parser: one decision per accepted byte.
  always_comb begin
    pos_next    = pos;
    half_next   = half;
    idx_next    = idx;
    sum_next    = sum;
    state_next  = state;
    item_load   = 1'b0;
    item_status = sfr_pkg::ST_OK;
    mem_we      = 1'b0;
    emit_start  = 1'b0;
    if (acc) begin
      priority if (pos == PW'(0)) begin
        if (is_delim) begin
          pos_next = PW'(1);
        end
      end else if (pos == PW'(1)) begin
        if (is_delim) begin
          pos_next = PW'(0);
        end else if (rx_byte >= 8'(MaxFrame)) begin
          pos_next    = PW'(0);
          item_load   = 1'b1;
          item_status = sfr_pkg::ST_BAD_FORMAT;
        end else begin
          idx_next = rx_byte;
          sum_next = rx_byte;
          pos_next = PW'(2);
        end
      end else if (pos >= PW'(MaxFrame)) begin
        pos_next    = PW'(0);
        half_next   = 1'b0;
        item_load   = 1'b1;
        item_status = sfr_pkg::ST_TOO_LONG;
      end else if (half) begin
        half_next = 1'b0;
        if (!is_delim) begin
          // A lone delimiter starts a new frame; this byte is its index.
          idx_next    = rx_byte;
          sum_next    = rx_byte;
          pos_next    = PW'(2);
          item_load   = 1'b1;
          item_status = sfr_pkg::ST_BAD_FORMAT;
        end
      end else if (8'(pos) == idx) begin
        // Checksum byte.
        pos_next  = PW'(0);
        half_next = 1'b0;
        if (sum != rx_byte) begin
          item_load   = 1'b1;
          item_status = sfr_pkg::ST_BAD_SUM;
        end else if (pos == PW'(2)) begin
          item_load   = 1'b1;
          item_status = sfr_pkg::ST_OK;
        end else begin
          state_next = S_EMIT;
          emit_start = 1'b1;
        end
      end else begin
        mem_we    = 1'b1;
        pos_next  = PW'(pos + PW'(1));
        sum_next  = sum + rx_byte;
        half_next = is_delim;
      end
    end
  end

  // Parser and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PARSE;
      pos   <= '0;
      half  <= 1'b0;
    end else begin
      pos  <= pos_next;
      half <= half_next;
      if (emit_adv && ptr_last) begin
        state <= S_PARSE;
      end else begin
        state <= state_next;
      end
    end
  end

  // Frame registers and play-out pointer.
  always_ff @(posedge clk) begin
    idx <= idx_next;
    sum <= sum_next;
    if (emit_start) begin
      ptr      <= AW'(2);
      last_ptr <= pos_m1[AW-1:0];
    end else if (emit_adv && !ptr_last) begin
      ptr <= AW'(ptr + AW'(1));
    end
  end

  // Output register: holds one beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_load || emit_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      msg_byte     <= 8'd0;
      has_byte     <= 1'b0;
      frame_status <= item_status;
      last_of_run  <= 1'b1;
    end else if (emit_adv) begin
      msg_byte     <= mem_rdata;
      has_byte     <= 1'b1;
      frame_status <= sfr_pkg::ST_OK;
      last_of_run  <= ptr_last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/serial_frame_receiver.sv -----
// A byte that ends a frame in error shows its status beat in the cycle after acceptance.
// A good checksum byte starts play-out: message bytes are read from the store into the
// output register, one beat a cycle while it is free. Throughput: one received byte a cycle
// while parsing and the output register is free; no byte is taken during play-out.
// Reset: parser waits for a delimiter, delimiter register returns to 0xBA, output empties;
// the frame store keeps its contents and needs no clearing pass.
`default_nettype none

module serial_frame_receiver #(
  parameter int MaxFrame = sfr_pkg::MAX_FRAME_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] msg_byte,
  output logic            has_byte,
  output logic      [1:0] frame_status,
  output logic            last_of_run
);

  `include "serial_frame_receiver_assert.svh"

  localparam int AW = $clog2(MaxFrame);

  logic [7:0]    delim;
  logic          busy;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Delimiter register; writes are taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= sfr_pkg::DELIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delim <= cfg_data;
    end
  end

  sfr_ctrl #(
    .MaxFrame(MaxFrame)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .delim        (delim),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .msg_byte     (msg_byte),
    .has_byte     (has_byte),
    .frame_status (frame_status),
    .last_of_run  (last_of_run),
    .busy         (busy),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  sfr_store #(
    .Depth(MaxFrame)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // No byte is taken and nothing is stored while a message is played out.
  `SFR_ASSERT_IMPL(a_no_accept_busy, busy, !in_ready && !mem_we,
                   "input accepted or store written during play-out")

  // A beat without a message byte always closes a frame.
  `SFR_ASSERT_IMPL(a_status_beat_last, out_valid && !has_byte, last_of_run,
                   "status beat not marked last")

  // Message beats always carry the good-frame status.
  `SFR_ASSERT_IMPL(a_msg_beat_ok, out_valid && has_byte,
                   frame_status == sfr_pkg::ST_OK,
                   "message beat with error status")

  // Play-out ends only on the beat marked last.
  `SFR_ASSERT_NEXT(a_busy_ends_last, busy && out_valid && last_of_run && has_byte,
                   !busy || !$stable(msg_byte) || out_valid,
                   "play-out did not end at the last beat")

endmodule

`default_nettype wire
